/* rtl/core/lp2c_pkg.sv */
package lp2c_pkg;

    localparam int CordicIters = 19;
    localparam int CwW = 33;
    localparam int ZwW = 26;
    localparam logic signed [CwW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam int PosMax = 524287;
    localparam int PosMin = -524288;

    localparam logic [2:0] CFG_OFS_X = 3'd0;
    localparam logic [2:0] CFG_OFS_Y = 3'd1;
    localparam logic [2:0] CFG_OFS_Z = 3'd2;
    localparam logic [2:0] CFG_ROLL  = 3'd3;
    localparam logic [2:0] CFG_PITCH = 3'd4;
    localparam logic [2:0] CFG_YAW   = 3'd5;
    localparam logic [2:0] CFG_NEAR  = 3'd6;

    localparam logic [17:0] NEAR_RESET = 18'd50000;

    typedef struct packed {
        logic [17:0]        range_mm;
        logic signed [15:0] azimuth;
        logic signed [15:0] elevation;
        logic [7:0]         intensity;
        logic               frame_end;
    } t_in;

    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic [17:0]        range_out;
        logic [7:0]         intensity_out;
        logic               is_near;
        logic               last_out;
    } t_out;

    typedef struct packed {
        logic [17:0] range_mm;
        logic [7:0]  intensity;
        logic        last;
        logic        near;
    } t_pass;

    function automatic logic signed [ZwW-1:0] atan_val(input int idx);
        logic signed [ZwW-1:0] v;
        case (idx)
            0:  v = 26'sd2097152;
            1:  v = 26'sd1238021;
            2:  v = 26'sd654136;
            3:  v = 26'sd332050;
            4:  v = 26'sd166669;
            5:  v = 26'sd83416;
            6:  v = 26'sd41718;
            7:  v = 26'sd20860;
            8:  v = 26'sd10430;
            9:  v = 26'sd5215;
            10: v = 26'sd2608;
            11: v = 26'sd1304;
            12: v = 26'sd652;
            13: v = 26'sd326;
            14: v = 26'sd163;
            15: v = 26'sd81;
            16: v = 26'sd41;
            17: v = 26'sd20;
            18: v = 26'sd10;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [19:0] sat_pos(input logic signed [27:0] v);
        logic signed [19:0] s;
        if (v > 28'(PosMax)) begin
            s = 20'sd524287;
        end else if (v < 28'(PosMin)) begin
            s = -20'sd524288;
        end else begin
            s = v[19:0];
        end
        return s;
    endfunction

endpackage

/* rtl/core/lidar_polar_to_cartesian.sv */
// Pipeline: an input stage, a CORDIC of 19 stages, then the sign fix, product, rounding and output stages.
// Throughput: one return per cycle while the output is taken; the three CORDIC pipelines and the multiplier
// stages each take a new item every cycle, and a stall holds only the full stages.
// Reset (synchronous, active low) clears all valid bits and loads the register
// defaults: offsets zero, near limit 50000 mm.
module lidar_polar_to_cartesian (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lp2c_pkg::t_in        i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lp2c_pkg::t_out       o_out_data,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [17:0]          i_cfg_data
);
    import lp2c_pkg::*;

    localparam int L = 26;
    localparam int NC = CordicIters;

    logic signed [15:0] r_ofs_x, r_ofs_y, r_ofs_z, r_roll, r_pitch, r_yaw;
    logic [17:0]        r_near_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs_x    <= '0;
            r_ofs_y    <= '0;
            r_ofs_z    <= '0;
            r_roll     <= '0;
            r_pitch    <= '0;
            r_yaw      <= '0;
            r_near_lim <= NEAR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OFS_X: r_ofs_x    <= i_cfg_data[15:0];
                CFG_OFS_Y: r_ofs_y    <= i_cfg_data[15:0];
                CFG_OFS_Z: r_ofs_z    <= i_cfg_data[15:0];
                CFG_ROLL:  r_roll     <= i_cfg_data[15:0];
                CFG_PITCH: r_pitch    <= i_cfg_data[15:0];
                CFG_YAW:   r_yaw      <= i_cfg_data[15:0];
                CFG_NEAR:  r_near_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [L:0] r_vld;
    logic [L:0] w_go;

    always_comb begin
        w_go[L] = !r_vld[L] || i_out_ready;
        for (int k = L - 1; k >= 0; k--) begin
            w_go[k] = !r_vld[k] || w_go[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_go[0]) r_vld[0] <= i_in_valid;
            for (int k = 1; k <= L; k++) begin
                if (w_go[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_in_ready  = w_go[0];
    assign o_out_valid = r_vld[L];

    t_pass r_pass [L:0];
    t_pass n_pass;

    assign n_pass = '{range_mm: i_in_data.range_mm, intensity: i_in_data.intensity,
                      last: i_in_data.frame_end, near: (i_in_data.range_mm < r_near_lim)};

    always_ff @(posedge i_clk) begin
        if (w_go[0]) r_pass[0] <= n_pass;
        for (int k = 1; k <= L; k++) begin
            if (w_go[k]) r_pass[k] <= r_pass[k-1];
        end
    end

    // CORDIC channels: 0 elevation, 1 azimuth, 2 roll
    logic signed [CwW-1:0] r_cx [3][NC+1];
    logic signed [CwW-1:0] r_cy [3][NC+1];
    logic signed [ZwW-1:0] r_cz [3][NC+1];
    logic                  r_flp [3][NC+1];
    logic [15:0]           w_ang [3];

    assign w_ang[0] = i_in_data.elevation + r_pitch;
    assign w_ang[1] = i_in_data.azimuth + r_yaw;
    assign w_ang[2] = r_roll;

    genvar ch, gi;
    generate
        for (ch = 0; ch < 3; ch++) begin : g_ch
            logic              w_flip;
            logic signed [15:0] w_t;
            assign w_flip = w_ang[ch][15] ^ w_ang[ch][14];
            assign w_t    = w_flip ? {~w_ang[ch][15], w_ang[ch][14:0]} : w_ang[ch];

            always_ff @(posedge i_clk) begin
                if (w_go[0]) begin
                    r_cx[ch][0]  <= CORDIC_GAIN;
                    r_cy[ch][0]  <= '0;
                    r_cz[ch][0]  <= {{(ZwW-24){w_t[15]}}, w_t, 8'h00};
                    r_flp[ch][0] <= w_flip;
                end
            end

            for (gi = 0; gi < NC; gi++) begin : g_it
                always_ff @(posedge i_clk) begin
                    if (w_go[gi+1]) begin
                        if (r_cz[ch][gi] >= 0) begin
                            r_cx[ch][gi+1] <= r_cx[ch][gi] - (r_cy[ch][gi] >>> gi);
                            r_cy[ch][gi+1] <= r_cy[ch][gi] + (r_cx[ch][gi] >>> gi);
                            r_cz[ch][gi+1] <= r_cz[ch][gi] - atan_val(gi);
                        end else begin
                            r_cx[ch][gi+1] <= r_cx[ch][gi] + (r_cy[ch][gi] >>> gi);
                            r_cy[ch][gi+1] <= r_cy[ch][gi] - (r_cx[ch][gi] >>> gi);
                            r_cz[ch][gi+1] <= r_cz[ch][gi] + atan_val(gi);
                        end
                        r_flp[ch][gi+1] <= r_flp[ch][gi];
                    end
                end
            end
        end
    endgenerate

    // stage 20: sign fix
    logic signed [CwW-1:0] r_cos20 [3];
    logic signed [CwW-1:0] r_sin20 [3];

    always_ff @(posedge i_clk) begin
        if (w_go[NC+1]) begin
            for (int c = 0; c < 3; c++) begin
                r_cos20[c] <= r_flp[c][NC] ? -r_cx[c][NC] : r_cx[c][NC];
                r_sin20[c] <= r_flp[c][NC] ? -r_cy[c][NC] : r_cy[c][NC];
            end
        end
    end

    // stage 21: range products
    logic signed [51:0]    r_prc21, r_pz21;
    logic signed [CwW-1:0] r_ct21, r_st21, r_cr21, r_sr21;
    logic signed [18:0]    w_r20;

    assign w_r20 = {1'b0, r_pass[NC+1].range_mm};

    always_ff @(posedge i_clk) begin
        if (w_go[NC+2]) begin
            r_prc21 <= w_r20 * r_cos20[0];
            r_pz21  <= w_r20 * r_sin20[0];
            r_ct21  <= r_cos20[1];
            r_st21  <= r_sin20[1];
            r_cr21  <= r_cos20[2];
            r_sr21  <= r_sin20[2];
        end
    end

    // stage 22: round to Q12
    logic signed [51:0]    w_rc_full, w_z1_full;
    logic signed [32:0]    r_rc22, r_z1_22;
    logic signed [CwW-1:0] r_ct22, r_st22, r_cr22, r_sr22;

    assign w_rc_full = (r_prc21 + 52'sd131072) >>> 18;
    assign w_z1_full = (r_pz21 + 52'sd131072) >>> 18;

    always_ff @(posedge i_clk) begin
        if (w_go[NC+3]) begin
            r_rc22  <= w_rc_full[32:0];
            r_z1_22 <= w_z1_full[32:0];
            r_ct22  <= r_ct21;
            r_st22  <= r_st21;
            r_cr22  <= r_cr21;
            r_sr22  <= r_sr21;
        end
    end

    // stage 23: azimuth products
    logic signed [65:0]    r_px23, r_py23;
    logic signed [32:0]    r_z1_23;
    logic signed [CwW-1:0] r_cr23, r_sr23;

    always_ff @(posedge i_clk) begin
        if (w_go[NC+4]) begin
            r_px23  <= r_rc22 * r_ct22;
            r_py23  <= r_rc22 * r_st22;
            r_z1_23 <= r_z1_22;
            r_cr23  <= r_cr22;
            r_sr23  <= r_sr22;
        end
    end

    // stage 24: round
    logic signed [65:0]    w_x_full, w_y1_full;
    logic signed [27:0]    r_x24;
    logic signed [33:0]    r_y1_24;
    logic signed [32:0]    r_z1_24;
    logic signed [CwW-1:0] r_cr24, r_sr24;

    assign w_x_full  = (r_px23 + (66'sd1 <<< 41)) >>> 42;
    assign w_y1_full = (r_py23 + (66'sd1 <<< 29)) >>> 30;

    always_ff @(posedge i_clk) begin
        if (w_go[NC+5]) begin
            r_x24   <= w_x_full[27:0];
            r_y1_24 <= w_y1_full[33:0];
            r_z1_24 <= r_z1_23;
            r_cr24  <= r_cr23;
            r_sr24  <= r_sr23;
        end
    end

    // stage 25: roll products
    logic signed [66:0] r_ycr25, r_zsr25, r_ysr25, r_zcr25;
    logic signed [27:0] r_x25;

    always_ff @(posedge i_clk) begin
        if (w_go[NC+6]) begin
            r_ycr25 <= r_y1_24 * r_cr24;
            r_ysr25 <= r_y1_24 * r_sr24;
            r_zsr25 <= r_z1_24 * r_sr24;
            r_zcr25 <= r_z1_24 * r_cr24;
            r_x25   <= r_x24;
        end
    end

    // stage 26: round, offset, saturate
    logic signed [67:0] w_y_full, w_z_full;
    logic signed [27:0] w_xo, w_yo, w_zo;
    t_out               r_out;

    assign w_y_full = (68'(r_ycr25) - 68'(r_zsr25) + (68'sd1 <<< 41)) >>> 42;
    assign w_z_full = (68'(r_ysr25) + 68'(r_zcr25) + (68'sd1 <<< 41)) >>> 42;
    assign w_xo = r_x25 + 28'(r_ofs_x);
    assign w_yo = w_y_full[27:0] + 28'(r_ofs_y);
    assign w_zo = w_z_full[27:0] + 28'(r_ofs_z);

    always_ff @(posedge i_clk) begin
        if (w_go[L]) begin
            r_out.pos_x         <= sat_pos(w_xo);
            r_out.pos_y         <= sat_pos(w_yo);
            r_out.pos_z         <= sat_pos(w_zo);
            r_out.range_out     <= r_pass[L-1].range_mm;
            r_out.intensity_out <= r_pass[L-1].intensity;
            r_out.is_near       <= r_pass[L-1].near;
            r_out.last_out      <= r_pass[L-1].last;
        end
    end

    assign o_out_data = r_out;

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[L] |-> o_in_ready)
        else $error("input stalled while output stage empty");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    a_near_zero_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_near_lim == 18'd0) && !$past(i_cfg_we, L + 1)
        && !$past(i_cfg_we, L) |-> !o_out_data.is_near)
        else $error("near flag set with zero near limit");

    a_range_matches_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.range_out == r_pass[L].range_mm))
        else $error("range lost its item");

endmodule

/* verif/testbench.sv */
module testbench;
    import lp2c_pkg::*;

    localparam logic signed [63:0] ATAN_STEP [19] = '{
        64'sd2097152, 64'sd1238021, 64'sd654136, 64'sd332050, 64'sd166669, 64'sd83416,
        64'sd41718, 64'sd20860, 64'sd10430, 64'sd5215, 64'sd2608, 64'sd1304, 64'sd652,
        64'sd326, 64'sd163, 64'sd81, 64'sd41, 64'sd20, 64'sd10
    };
    localparam int POINTS_RANDOM = 950;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [17:0] i_cfg_data;

    lidar_polar_to_cartesian dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    logic signed [15:0] ofs_x, ofs_y, ofs_z;
    logic [15:0]        roll_ang, pitch_ang, yaw_ang;
    logic [17:0]        near_mm;

    t_in  return_q [$];
    t_out point_q [$];
    int   err_cnt;
    int   in_gap;
    int   out_gap;
    int   max_gap;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic signed [63:0] floor_shift(input logic signed [63:0] v, input int n);
        return v >>> n;
    endfunction

    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic void cordic_sincos(input logic [15:0] ang,
                                          output logic signed [63:0] c,
                                          output logic signed [63:0] s);
        logic               flip;
        logic [15:0]        a2;
        logic signed [63:0] x, y, z, dx, dy;
        flip = ang[15] ^ ang[14];
        a2 = flip ? ang - 16'd32768 : ang;
        x = 64'sd652032874;
        y = 0;
        z = 64'(signed'(a2)) * 256;
        for (int i = 0; i < 19; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic signed [19:0] clamp20(input logic signed [63:0] v);
        if (v > 64'sd524287) begin
            return 20'sd524287;
        end
        if (v < -64'sd524288) begin
            return -20'sd524288;
        end
        return v[19:0];
    endfunction

    function automatic t_out project_point(input t_in p);
        logic signed [63:0] cp, sp, ct, st, cr, sr, r, rc, y1, z1, x, y, z;
        t_out o;
        cordic_sincos(p.elevation + pitch_ang, cp, sp);
        cordic_sincos(p.azimuth + yaw_ang, ct, st);
        cordic_sincos(roll_ang, cr, sr);
        r = 64'(p.range_mm);
        rc = round_shift(r * cp, 18);
        x = round_shift(rc * ct, 42);
        y1 = round_shift(rc * st, 30);
        z1 = round_shift(r * sp, 18);
        y = round_shift(y1 * cr - z1 * sr, 42);
        z = round_shift(y1 * sr + z1 * cr, 42);
        o.pos_x = clamp20(x + 64'(ofs_x));
        o.pos_y = clamp20(y + 64'(ofs_y));
        o.pos_z = clamp20(z + 64'(ofs_z));
        o.range_out = p.range_mm;
        o.intensity_out = p.intensity;
        o.is_near = p.range_mm < near_mm;
        o.last_out = p.frame_end;
        return o;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_OFS_X: ofs_x = val[15:0];
            CFG_OFS_Y: ofs_y = val[15:0];
            CFG_OFS_Z: ofs_z = val[15:0];
            CFG_ROLL:  roll_ang = val[15:0];
            CFG_PITCH: pitch_ang = val[15:0];
            CFG_YAW:   yaw_ang = val[15:0];
            CFG_NEAR:  near_mm = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain;
        wait (return_q.size() == 0 && point_q.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_in make_return(input logic [17:0] r, input logic [15:0] az,
                                        input logic [15:0] el, input logic [7:0] it,
                                        input logic fe);
        t_in p;
        p.range_mm = r;
        p.azimuth = az;
        p.elevation = el;
        p.intensity = it;
        p.frame_end = fe;
        return p;
    endfunction

    function automatic t_in rand_return;
        logic [17:0] r;
        case ($urandom_range(0, 3))
            0: r = 18'($urandom_range(0, 1000));
            1: r = 18'h3FFFF - 18'($urandom_range(0, 1000));
            default: r = 18'($urandom);
        endcase
        return make_return(r, 16'($urandom), 16'($urandom), 8'($urandom),
                           1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [17:0] rand_cfg(input logic [2:0] idx);
        case ($urandom_range(0, 3))
            0: return (idx == CFG_NEAR) ? 18'h3FFFF : 18'h07FFF;
            1: return (idx == CFG_NEAR) ? 18'h00000 : 18'h08000;
            default: return 18'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                point_q.push_back(project_point(i_in_data));
            end
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (return_q.size() > 0) begin
                i_in_data <= return_q.pop_front();
                i_in_valid <= 1'b1;
                in_gap <= $urandom_range(0, max_gap);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out exp_pt;
        int   gap;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (point_q.size() == 0) begin
                    $display("%0t unexpected point: actual %h", $time, o_out_data);
                    err_cnt++;
                end else begin
                    exp_pt = point_q.pop_front();
                    if (exp_pt !== o_out_data) begin
                        $display("%0t mismatch: expected x=%0d y=%0d z=%0d r=%0d i=%0d n=%0d l=%0d",
                                 $time, exp_pt.pos_x, exp_pt.pos_y, exp_pt.pos_z,
                                 exp_pt.range_out, exp_pt.intensity_out, exp_pt.is_near,
                                 exp_pt.last_out);
                        $display("%0t          actual   x=%0d y=%0d z=%0d r=%0d i=%0d n=%0d l=%0d",
                                 $time, o_out_data.pos_x, o_out_data.pos_y, o_out_data.pos_z,
                                 o_out_data.range_out, o_out_data.intensity_out,
                                 o_out_data.is_near, o_out_data.last_out);
                        err_cnt++;
                    end
                end
            end
            if (o_out_valid && i_out_ready) begin
                gap = $urandom_range(0, max_gap);
                out_gap <= gap;
                i_out_ready <= (gap == 0);
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_ready <= (out_gap == 1);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        err_cnt = 0;
        max_gap = 0;
        ofs_x = 0;
        ofs_y = 0;
        ofs_z = 0;
        roll_ang = 0;
        pitch_ang = 0;
        yaw_ang = 0;
        near_mm = NEAR_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        return_q.push_back(make_return(18'd0, 16'h0000, 16'h0000, 8'd0, 1'b0));
        return_q.push_back(make_return(18'h3FFFF, 16'h7FFF, 16'h8000, 8'hFF, 1'b1));
        return_q.push_back(make_return(18'h3FFFF, 16'h8000, 16'h7FFF, 8'h55, 1'b0));
        return_q.push_back(make_return(18'd49999, 16'h4000, 16'h0000, 8'hAA, 1'b1));
        return_q.push_back(make_return(18'd50000, 16'hC000, 16'h4000, 8'h01, 1'b0));
        return_q.push_back(make_return(18'h3FFFF, 16'h0000, 16'hC000, 8'h80, 1'b0));
        return_q.push_back(make_return(18'h2AAAA, 16'h3FFF, 16'hBFFF, 8'h7F, 1'b1));
        drain();

        write_reg(CFG_OFS_X, 18'h07FFF);
        write_reg(CFG_OFS_Y, 18'h08000);
        write_reg(CFG_OFS_Z, 18'h07FFF);
        write_reg(CFG_ROLL, 18'h08000);
        write_reg(CFG_PITCH, 18'h07FFF);
        write_reg(CFG_YAW, 18'h3C000);
        write_reg(CFG_NEAR, 18'd0);
        write_reg(3'd7, 18'h12345);
        return_q.push_back(make_return(18'h3FFFF, 16'h7FFF, 16'h7FFF, 8'h0F, 1'b1));
        return_q.push_back(make_return(18'h3FFFF, 16'h4000, 16'h0001, 8'hF0, 1'b0));
        return_q.push_back(make_return(18'd0, 16'h8000, 16'h8000, 8'h33, 1'b1));
        return_q.push_back(make_return(18'h3FFFF, 16'hFFFF, 16'h4000, 8'hCC, 1'b0));
        drain();
        write_reg(CFG_NEAR, 18'h3FFFF);
        write_reg(CFG_ROLL, 18'h04000);
        return_q.push_back(make_return(18'h3FFFE, 16'h1234, 16'h8001, 8'h11, 1'b0));
        return_q.push_back(make_return(18'h3FFFF, 16'h0000, 16'h0000, 8'h22, 1'b1));
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            for (int k = 0; k < 7; k++) begin
                if ($urandom_range(0, 1)) begin
                    write_reg(k[2:0], rand_cfg(k[2:0]));
                end
            end
            max_gap = (ph % 3 == 0) ? 0 : 18;
            for (int n = 0; n < POINTS_RANDOM / 10; n++) begin
                return_q.push_back(rand_return());
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
